// ----- rtl/gpsr_pkg.sv -----
// ----------------------------------------------------------------------------
// gpsr_pkg
// Shared types and constants for the game-pad slave responder.
// ----------------------------------------------------------------------------
package gpsr_pkg;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_RX_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DESELECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMULATE_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_FACE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_SHOULDERS = 2'd2;

  localparam logic [7:0] BYTE_OPEN      = 8'h01;
  localparam logic [7:0] BYTE_ID        = 8'h41;
  localparam logic [7:0] BYTE_POLL      = 8'h42;
  localparam logic [7:0] BYTE_READY     = 8'h5A;
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;

  typedef struct packed {
    logic emulate_select;
    logic rotate_face;
    logic swap_shoulders;
  } gpsr_cfg_t;

  typedef struct packed {
    logic       poll_request;
    logic       ack;
    logic [7:0] tx_byte;
  } gpsr_result_t;

endpackage

// ----- rtl/game_pad_slave_responder_top.sv -----
// ----------------------------------------------------------------------------
// game_pad_slave_responder_top
// Game-pad slave responder with stream input and output.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the input register stalls. An item passes
// from the input register through the responder into the output register; a
// received byte yields one result, a deselect or a pad sample yields none. Throughput
// is held at one item per cycle while the output side keeps tready high;
// the input register stalls only when the output register is full and not
// being taken. Configuration writes act on the next pad sample processed.
module game_pad_slave_responder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // rx_byte[7:0], pad_word[23:8]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // tx_byte[7:0], ack[8], poll_request[9], zero[15:10]
  input  logic        cfg_we,
  input  logic [gpsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        cfg_data
);
  import gpsr_pkg::*;

  gpsr_cfg_t    cfg;
  logic         in_valid;
  logic [1:0]   in_kind;
  logic [7:0]   in_rx_byte;
  logic [15:0]  in_pad_word;
  logic         proc_fire;
  logic [7:0]   report0, report1;
  gpsr_result_t result, out_result;
  logic         out_valid;
  logic         is_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EMULATE_SELECT: cfg.emulate_select <= cfg_data;
        CFG_ROTATE_FACE:    cfg.rotate_face    <= cfg_data;
        CFG_SWAP_SHOULDERS: cfg.swap_shoulders <= cfg_data;
        default: ;
      endcase
    end
  end

  assign proc_fire = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || proc_fire;
  assign is_byte   = (in_kind == KIND_RX_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind     <= s_tuser;
      in_rx_byte  <= s_tdata[7:0];
      in_pad_word <= s_tdata[23:8];
    end
  end

  gpsr_report u_report (
    .clk      (clk),
    .rst      (rst),
    .load     (proc_fire && (in_kind == KIND_SAMPLE)),
    .pad_word (in_pad_word),
    .cfg      (cfg),
    .report0  (report0),
    .report1  (report1)
  );

  gpsr_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (proc_fire && is_byte),
    .deselect (proc_fire && (in_kind == KIND_DESELECT)),
    .rx_byte  (in_rx_byte),
    .report0  (report0),
    .report1  (report1),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && is_byte) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && is_byte) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_result.poll_request, out_result.ack, out_result.tx_byte};

endmodule

// ----- rtl/gpsr_report.sv -----
// ----------------------------------------------------------------------------
// gpsr_report
// Remaps a sampled pad word into the two active-low report bytes and holds
// them until the next sample.
// ----------------------------------------------------------------------------
module gpsr_report (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [15:0]       pad_word,
  input  gpsr_pkg::gpsr_cfg_t cfg,
  output logic [7:0]        report0,
  output logic [7:0]        report1
);
  import gpsr_pkg::*;

  logic z, y, x, r, b, c, a, st, up, dn, lt, rt, l;
  logic st_eff, sl;
  logic [7:0] report0_next, report1_next;
  logic [3:0] shoulders, face;

  assign z  = pad_word[0];
  assign y  = pad_word[1];
  assign x  = pad_word[2];
  assign r  = pad_word[3];
  assign b  = pad_word[4];
  assign c  = pad_word[5];
  assign a  = pad_word[6];
  assign st = pad_word[7];
  assign up = pad_word[8];
  assign dn = pad_word[9];
  assign lt = pad_word[10];
  assign rt = pad_word[11];
  assign l  = pad_word[15];

  always_comb begin
    // with emulate_select set, up and start held together report as select
    if (cfg.emulate_select && !up && !st) begin
      st_eff = 1'b1;
      sl     = 1'b0;
    end else begin
      st_eff = st;
      sl     = 1'b1;
    end
    report0_next = {lt, dn, rt, up, st_eff, 1'b1, 1'b1, sl};
    shoulders = cfg.swap_shoulders ? {r, l, c, z} : {c, z, r, l};
    face      = cfg.rotate_face    ? {a, b, y, x} : {x, a, b, y};
    report1_next = {face, shoulders};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report0 <= BYTE_IDLE;
      report1 <= BYTE_IDLE;
    end else if (load) begin
      report0 <= report0_next;
      report1 <= report1_next;
    end
  end

endmodule

// ----- rtl/gpsr_fsm.sv -----
// ----------------------------------------------------------------------------
// gpsr_fsm
// Protocol responder: tracks the exchange and picks the answer byte.
// ----------------------------------------------------------------------------
module gpsr_fsm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   deselect,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             report0,
  input  logic [7:0]             report1,
  output gpsr_pkg::gpsr_result_t result
);
  import gpsr_pkg::*;

  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_POLL   = 3'd1;
  localparam logic [2:0] ST_DATA1  = 3'd2;
  localparam logic [2:0] ST_DATA2  = 3'd3;
  localparam logic [2:0] ST_IGNORE = 3'd4;

  logic [2:0] proto_state, proto_state_next;

  always_comb begin
    result.tx_byte      = BYTE_IDLE;
    result.ack          = 1'b0;
    result.poll_request = 1'b0;
    proto_state_next    = proto_state;
    unique case (proto_state)
      ST_POLL: begin
        if (rx_byte == BYTE_POLL) begin
          result.tx_byte   = BYTE_READY;
          result.ack       = 1'b1;
          proto_state_next = ST_DATA1;
        end else begin
          proto_state_next = ST_START;
        end
      end
      ST_DATA1: begin
        result.tx_byte   = report0;
        result.ack       = 1'b1;
        proto_state_next = ST_DATA2;
      end
      ST_DATA2: begin
        result.tx_byte   = report1;
        result.ack       = 1'b1;
        proto_state_next = ST_START;
      end
      ST_IGNORE: begin
        proto_state_next = ST_IGNORE;
      end
      default: begin
        // start, and unused codes treated as start
        if (rx_byte == BYTE_OPEN) begin
          result.tx_byte      = BYTE_ID;
          result.ack          = 1'b1;
          result.poll_request = 1'b1;
          proto_state_next    = ST_POLL;
        end else begin
          proto_state_next = ST_IGNORE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proto_state <= ST_START;
    end else if (deselect) begin
      proto_state <= ST_START;
    end else if (step) begin
      proto_state <= proto_state_next;
    end
  end

endmodule
